@@ sv/bgt_pkg.sv @@
// ============================================================================
// bgt_pkg: shared types and constants of the butterfly gate transform.
// Holds the field widths, register indexes and the rounding helper.
// ============================================================================
package bgt_pkg;

    localparam int MaxQubits  = 6;
    localparam int StoreDepth = 1 << MaxQubits;
    localparam int AddrW      = MaxQubits;
    localparam int CountW     = MaxQubits + 1;
    localparam int SampleW    = 16;
    localparam int WordW      = 2 * SampleW;
    localparam int CfgAddrW   = 3;
    localparam int CfgDataW   = 16;
    localparam int ProdW      = 2 * SampleW;
    localparam int SumW       = ProdW + 2;

    typedef enum logic [CfgAddrW-1:0] {
        REG_QUBIT_COUNT = 3'd0,
        REG_GATE_A      = 3'd1,
        REG_GATE_B      = 3'd2,
        REG_GATE_C      = 3'd3,
        REG_GATE_D      = 3'd4
    } cfg_reg_t;

    typedef logic signed [SampleW-1:0] sample_t;

    // Rounds a Q2.28 sum to Q1.14, ties toward plus infinity, with saturation.
    function automatic sample_t round_sat(input logic signed [SumW-1:0] s);
        logic signed [SumW-1:0] r;
        begin
            r = (s + SumW'(8192)) >>> 14;
            if (r > SumW'(32767))
                round_sat = 16'sh7FFF;
            else if (r < -SumW'(32768))
                round_sat = 16'sh8000;
            else
                round_sat = r[SampleW-1:0];
        end
    endfunction

endpackage

@@ sv/bgt_stream_if.sv @@
// ============================================================================
// bgt_stream_if: valid/ready channel for input items and result items.
// The payload carries every field of both directions; unused ones idle.
// ============================================================================
interface bgt_stream_if;
    logic                 valid;
    logic                 ready;
    logic signed [15:0]   in_re;
    logic signed [15:0]   in_im;
    logic signed [15:0]   out_re;
    logic signed [15:0]   out_im;
    logic [5:0]           out_index;
    logic                 out_last;

    modport source (output valid, in_re, in_im, out_re, out_im, out_index, out_last,
                    input ready);
    modport sink   (input valid, in_re, in_im, out_re, out_im, out_index, out_last,
                    output ready);
endinterface

@@ sv/butterfly_gate_transform_unit.sv @@
// ============================================================================
// butterfly_gate_transform_unit: real 2x2 gate applied to every qubit.
// Loads 2^n amplitudes, runs n butterfly stages, then streams them out.
// ============================================================================
// Loading accepts one item per cycle. When the vector is complete the block
// runs n stages of 2^(n-1) butterflies each; each butterfly steps through
// read x[i], read x[j], multiply, write x[i] and write x[j], an order set by
// the single-read, single-write amplitude memory. The vector then leaves
// in index order through a one-entry output register. A memory read is
// issued only when no read is pending and the output register is free or
// being taken, so each read waits until the data of the last one has landed,
// and the vector leaves more slowly while the receiver stalls.
// Input is not accepted during the transform or the emit phase.
module butterfly_gate_transform_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [bgt_pkg::CfgAddrW-1:0]  cfg_index,
    input  logic [bgt_pkg::CfgDataW-1:0]  cfg_data,
    bgt_stream_if.sink                    in_ch,
    bgt_stream_if.source                  out_ch
);
    import bgt_pkg::*;

    typedef enum logic [4:0] {
        S_LOAD = 5'b00001,
        S_RDI  = 5'b00010,
        S_RDJ  = 5'b00100,
        S_MUL  = 5'b01000,
        S_WR   = 5'b10000
    } bf_state_t;

    typedef enum logic [1:0] {
        P_LOAD = 2'b01,
        P_EMIT = 2'b10
    } phase_t;

    // Configuration registers.
    logic [2:0] qubit_count_reg;
    sample_t    gate_a_reg, gate_b_reg, gate_c_reg, gate_d_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qubit_count_reg <= 3'd6;
            gate_a_reg      <= 16'sd11585;
            gate_b_reg      <= 16'sd11585;
            gate_c_reg      <= 16'sd11585;
            gate_d_reg      <= -16'sd11585;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_QUBIT_COUNT: qubit_count_reg <= cfg_data[2:0];
                REG_GATE_A:      gate_a_reg      <= cfg_data;
                REG_GATE_B:      gate_b_reg      <= cfg_data;
                REG_GATE_C:      gate_c_reg      <= cfg_data;
                REG_GATE_D:      gate_d_reg      <= cfg_data;
                default: ;
            endcase
        end
    end

    // The qubit count is clamped to 1..MaxQubits.
    logic [2:0] n_act;
    always_comb
    begin
        if (qubit_count_reg == 3'd0)
            n_act = 3'd1;
        else if (qubit_count_reg > 3'(MaxQubits))
            n_act = 3'(MaxQubits);
        else
            n_act = qubit_count_reg;
    end
    logic [CountW-1:0] size;
    assign size = CountW'(1) << n_act;

    // Amplitude memory.
    logic             ram_we;
    logic [AddrW-1:0] ram_waddr, ram_raddr;
    logic [WordW-1:0] ram_wdata, ram_rdata;

    bgt_ram #(.Width(WordW), .Depth(StoreDepth)) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Sequencer state.
    bf_state_t         state_reg;
    phase_t            phase_reg;
    logic              busy_reg;      // transform running
    logic [CountW-1:0] load_count_reg;
    logic [2:0]        stage_reg;     // index of current stage bit
    logic [AddrW-1:0]  pair_reg;      // butterfly counter within a stage
    logic [CountW-1:0] emit_reg;      // next memory address to read out
    logic              rd_pend_reg;   // read data arrives next cycle
    logic [AddrW-1:0]  rd_idx_reg;
    logic [WordW-1:0]  x_reg, y_reg;
    logic signed [ProdW-1:0] p_ar_reg, p_br_reg, p_ai_reg, p_bi_reg;
    logic signed [ProdW-1:0] p_cr_reg, p_dr_reg, p_ci_reg, p_di_reg;
    logic              wr_hi_reg;     // second write of a butterfly

    // Output register.
    logic              ov_reg;
    sample_t           ore_reg, oim_reg;
    logic [AddrW-1:0]  oidx_reg;
    logic              olast_reg;

    // Pair addresses: insert a zero at the stage bit of the pair counter.
    logic [AddrW-1:0] bitmask, low_mask, addr_i, addr_j;
    assign bitmask  = AddrW'(1) << stage_reg;
    assign low_mask = bitmask - AddrW'(1);
    assign addr_i   = ((pair_reg & ~low_mask) << 1) | (pair_reg & low_mask);
    assign addr_j   = addr_i | bitmask;

    logic [AddrW-1:0] half_m1;
    assign half_m1 = AddrW'((size >> 1) - CountW'(1));

    assign in_ch.ready = (phase_reg == P_LOAD) && !busy_reg;
    logic in_acc;
    assign in_acc = in_ch.valid && in_ch.ready;

    // A read is issued only when its data can land in a free output register.
    logic out_free;
    assign out_free = !ov_reg || out_ch.ready;
    logic emit_rd;
    assign emit_rd = (phase_reg == P_EMIT) && (emit_reg < size) &&
                     !rd_pend_reg && out_free;

    logic signed [SumW-1:0] s_ir, s_ii, s_jr, s_ji;
    assign s_ir = SumW'(p_ar_reg) + SumW'(p_br_reg);
    assign s_ii = SumW'(p_ai_reg) + SumW'(p_bi_reg);
    assign s_jr = SumW'(p_cr_reg) + SumW'(p_dr_reg);
    assign s_ji = SumW'(p_ci_reg) + SumW'(p_di_reg);

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = load_count_reg[AddrW-1:0];
        ram_wdata = {in_ch.in_im, in_ch.in_re};
        ram_raddr = emit_reg[AddrW-1:0];
        if (in_acc)
            ram_we = 1'b1;
        unique case (state_reg)
            S_RDI: ram_raddr = addr_i;
            S_RDJ: ram_raddr = addr_j;
            S_WR:
            begin
                ram_we = 1'b1;
                if (wr_hi_reg)
                begin
                    ram_waddr = addr_j;
                    ram_wdata = {round_sat(s_ji), round_sat(s_jr)};
                end
                else
                begin
                    ram_waddr = addr_i;
                    ram_wdata = {round_sat(s_ii), round_sat(s_ir)};
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_LOAD;
            phase_reg      <= P_LOAD;
            busy_reg       <= 1'b0;
            load_count_reg <= '0;
            stage_reg      <= '0;
            pair_reg       <= '0;
            emit_reg       <= '0;
            rd_pend_reg    <= 1'b0;
            rd_idx_reg     <= '0;
            x_reg          <= '0;
            y_reg          <= '0;
            wr_hi_reg      <= 1'b0;
            ov_reg         <= 1'b0;
            ore_reg        <= '0;
            oim_reg        <= '0;
            oidx_reg       <= '0;
            olast_reg      <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_LOAD:
                begin
                    if (in_acc)
                    begin
                        if (load_count_reg + CountW'(1) >= size)
                        begin
                            load_count_reg <= '0;
                            busy_reg       <= 1'b1;
                            state_reg      <= S_RDI;
                            stage_reg      <= n_act - 3'd1;
                            pair_reg       <= '0;
                        end
                        else
                            load_count_reg <= load_count_reg + CountW'(1);
                    end
                end
                S_RDI: state_reg <= S_RDJ;
                S_RDJ:
                begin
                    x_reg     <= ram_rdata;
                    state_reg <= S_MUL;
                end
                S_MUL:
                begin
                    y_reg     <= ram_rdata;
                    wr_hi_reg <= 1'b0;
                    state_reg <= S_WR;
                end
                S_WR:
                begin
                    if (!wr_hi_reg)
                        wr_hi_reg <= 1'b1;
                    else if (pair_reg == half_m1)
                    begin
                        pair_reg <= '0;
                        if (stage_reg == 3'd0)
                        begin
                            busy_reg  <= 1'b0;
                            phase_reg <= P_EMIT;
                            emit_reg  <= '0;
                            state_reg <= S_LOAD;
                        end
                        else
                        begin
                            stage_reg <= stage_reg - 3'd1;
                            state_reg <= S_RDI;
                        end
                    end
                    else
                    begin
                        pair_reg  <= pair_reg + AddrW'(1);
                        state_reg <= S_RDI;
                    end
                end
                default: state_reg <= S_LOAD;
            endcase

            // Emit: the read address is issued in the cycle before the output load.
            rd_pend_reg <= emit_rd;
            if (emit_rd)
            begin
                rd_idx_reg  <= emit_reg[AddrW-1:0];
                emit_reg    <= emit_reg + CountW'(1);
            end
            if (rd_pend_reg)
            begin
                ov_reg    <= 1'b1;
                ore_reg   <= ram_rdata[SampleW-1:0];
                oim_reg   <= ram_rdata[WordW-1:SampleW];
                oidx_reg  <= rd_idx_reg;
                olast_reg <= (CountW'(rd_idx_reg) + CountW'(1) == size);
                if (CountW'(rd_idx_reg) + CountW'(1) == size)
                    phase_reg <= P_LOAD;
            end
            else if (out_ch.ready)
                ov_reg <= 1'b0;
        end
    end

    // Products of the butterfly, registered before the sum.
    always_ff @(posedge clk)
    begin
        if (state_reg == S_WR && !wr_hi_reg)
        begin
            p_ar_reg <= ProdW'(gate_a_reg) * ProdW'(sample_t'(x_reg[SampleW-1:0]));
            p_br_reg <= ProdW'(gate_b_reg) * ProdW'(sample_t'(y_reg[SampleW-1:0]));
            p_ai_reg <= ProdW'(gate_a_reg) * ProdW'(sample_t'(x_reg[WordW-1:SampleW]));
            p_bi_reg <= ProdW'(gate_b_reg) * ProdW'(sample_t'(y_reg[WordW-1:SampleW]));
        end
        if (state_reg == S_MUL)
        begin
            p_ar_reg <= ProdW'(gate_a_reg) * ProdW'(sample_t'(x_reg[SampleW-1:0]));
            p_br_reg <= ProdW'(gate_b_reg) * ProdW'(sample_t'(ram_rdata[SampleW-1:0]));
            p_ai_reg <= ProdW'(gate_a_reg) * ProdW'(sample_t'(x_reg[WordW-1:SampleW]));
            p_bi_reg <= ProdW'(gate_b_reg) * ProdW'(sample_t'(ram_rdata[WordW-1:SampleW]));
            p_cr_reg <= ProdW'(gate_c_reg) * ProdW'(sample_t'(x_reg[SampleW-1:0]));
            p_dr_reg <= ProdW'(gate_d_reg) * ProdW'(sample_t'(ram_rdata[SampleW-1:0]));
            p_ci_reg <= ProdW'(gate_c_reg) * ProdW'(sample_t'(x_reg[WordW-1:SampleW]));
            p_di_reg <= ProdW'(gate_d_reg) * ProdW'(sample_t'(ram_rdata[WordW-1:SampleW]));
        end
    end

    assign out_ch.valid     = ov_reg;
    assign out_ch.out_re    = ore_reg;
    assign out_ch.out_im    = oim_reg;
    assign out_ch.out_index = oidx_reg;
    assign out_ch.out_last  = olast_reg;
    assign out_ch.in_re     = '0;
    assign out_ch.in_im     = '0;
endmodule

@@ sv/bgt_ram.sv @@
// ============================================================================
// bgt_ram: generic single-port-write, single-port-read RAM.
// Read data is registered and appears in the cycle after the address.
// ============================================================================
module bgt_ram #(
    parameter int Width = 32,
    parameter int Depth = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] waddr,
    input  logic [Width-1:0]         wdata,
    input  logic [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end
endmodule

@@ dv/tb_top.sv @@
// ============================================================================
// tb_top: testbench of the butterfly gate transform unit
// Loads amplitude vectors under a range of qubit counts and gate settings,
// predicts every transformed amplitude and checks each result item in order.
// ============================================================================
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import bgt_pkg::*;

    // One expected result item: both parts of the amplitude, its index and
    // the end-of-vector flag.
    typedef struct {
        logic signed [15:0] re;
        logic signed [15:0] im;
        logic [5:0]         index;
        logic               last;
    } amp_result_t;

    // Scoreboard: holds its own copy of the amplitude store, the load count
    // and the register file, runs the butterfly network whenever a vector is
    // complete and queues the amplitudes that the block must emit.
    class amp_scoreboard;
        logic signed [15:0] store_re [64];
        logic signed [15:0] store_im [64];
        int unsigned        loaded;
        logic [2:0]         qubits;
        logic signed [15:0] ga, gb, gc, gd;
        amp_result_t        amp_queue [$];
        int                 errors;

        function new();
            loaded = 0;
            qubits = 3'd6;
            ga = 16'sd11585;
            gb = 16'sd11585;
            gc = 16'sd11585;
            gd = -16'sd11585;
            errors = 0;
        endfunction

        function void write_reg(input logic [2:0] idx, input logic [15:0] data);
            case (idx)
                REG_QUBIT_COUNT: qubits = data[2:0];
                REG_GATE_A:      ga = data;
                REG_GATE_B:      gb = data;
                REG_GATE_C:      gc = data;
                REG_GATE_D:      gd = data;
                default:         ;
            endcase
        endfunction

        // Q2.28 sum to Q1.14, half rounds up, then clamp to 16 bits.
        function logic signed [15:0] q14(input longint acc);
            longint r;
            r = (acc + 64'sd8192) >>> 14;
            if (r > 32767)
                return 16'sh7FFF;
            if (r < -32768)
                return 16'sh8000;
            return r[15:0];
        endfunction

        function void note_input(input logic signed [15:0] re,
                                 input logic signed [15:0] im);
            int unsigned nq, size, bitv, i, j;
            longint xr, xi, yr, yi;
            amp_result_t e;
            nq = (qubits == 0) ? 1 : ((qubits > MaxQubits) ? MaxQubits : qubits);
            size = 1 << nq;
            store_re[loaded % 64] = re;
            store_im[loaded % 64] = im;
            loaded = (loaded + 1) % 128;
            if (loaded < size)
                return;
            loaded = 0;
            for (int k = 0; k < nq; k++) begin
                bitv = 1 << (nq - 1 - k);
                for (i = 0; i < size; i++) begin
                    if ((i & bitv) == 0) begin
                        j = i + bitv;
                        xr = store_re[i];
                        xi = store_im[i];
                        yr = store_re[j];
                        yi = store_im[j];
                        store_re[i] = q14(longint'(ga) * xr + longint'(gb) * yr);
                        store_im[i] = q14(longint'(ga) * xi + longint'(gb) * yi);
                        store_re[j] = q14(longint'(gc) * xr + longint'(gd) * yr);
                        store_im[j] = q14(longint'(gc) * xi + longint'(gd) * yi);
                    end
                end
            end
            for (i = 0; i < size; i++) begin
                e.re = store_re[i];
                e.im = store_im[i];
                e.index = i[5:0];
                e.last = (i + 1 == size);
                amp_queue.push_back(e);
            end
        endfunction

        function void check_result(input amp_result_t got);
            amp_result_t want;
            if (amp_queue.size() == 0) begin
                $display("%0t: unexpected amplitude re=%0d im=%0d index=%0d last=%0b",
                         $time, got.re, got.im, got.index, got.last);
                errors++;
                return;
            end
            want = amp_queue.pop_front();
            if (got.re !== want.re) begin
                $display("%0t: out_re expected %0d actual %0d", $time, want.re, got.re);
                errors++;
            end
            if (got.im !== want.im) begin
                $display("%0t: out_im expected %0d actual %0d", $time, want.im, got.im);
                errors++;
            end
            if (got.index !== want.index) begin
                $display("%0t: out_index expected %0d actual %0d",
                         $time, want.index, got.index);
                errors++;
            end
            if (got.last !== want.last) begin
                $display("%0t: out_last expected %0b actual %0b",
                         $time, want.last, got.last);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [15:0] cfg_data;

    bgt_stream_if in_ch ();
    bgt_stream_if out_ch ();

    amp_scoreboard sb;

    // Sender burst state: items left in the current burst.
    int burst_left;
    int sent_items;

    butterfly_gate_transform_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // The receiver alternates between stretches of full throughput and
    // stretches of random stalls, so backpressure lands on every phase.
    int unsigned stall_mode;
    int unsigned stall_timer;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
            stall_mode   <= 0;
            stall_timer  <= 0;
        end
        else
        begin
            if (stall_timer == 0)
            begin
                stall_mode  <= $urandom_range(0, 2);
                stall_timer <= $urandom_range(20, 150);
            end
            else
                stall_timer <= stall_timer - 1;
            case (stall_mode)
                0:       out_ch.ready <= 1'b1;
                1:       out_ch.ready <= ($urandom_range(0, 3) != 0);
                default: out_ch.ready <= ($urandom_range(0, 4) == 0);
            endcase
        end
    end

    // Every accepted result goes to the scoreboard. Values are read at the
    // edge itself, so they are the ones that stood before it.
    always @(posedge clk)
    begin
        amp_result_t got;
        if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
        begin
            got.re    = out_ch.out_re;
            got.im    = out_ch.out_im;
            got.index = out_ch.out_index;
            got.last  = out_ch.out_last;
            sb.check_result(got);
        end
    end

    // Register writes happen only while the block is idle.
    task automatic write_cfg(input logic [2:0] idx, input logic [15:0] data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we    <= 1'b0;
        sb.write_reg(idx, data);
    endtask

    // Presents one amplitude and holds it until the block takes it. Between
    // bursts valid drops at the last acceptance edge for a random gap; inside
    // a burst it stays high.
    task automatic send_amp(input logic signed [15:0] re,
                            input logic signed [15:0] im);
        if (burst_left == 0)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 8);
        end
        in_ch.valid <= 1'b1;
        in_ch.in_re <= re;
        in_ch.in_im <= im;
        @(posedge clk);
        while (in_ch.ready !== 1'b1)
            @(posedge clk);
        sb.note_input(re, im);
        sent_items++;
        burst_left--;
    endtask

    // Drops valid at the edge of the last acceptance, then waits until the
    // block has emitted every amplitude it owes.
    task automatic drain;
        in_ch.valid <= 1'b0;
        burst_left = 0;
        while (sb.amp_queue.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    function automatic logic signed [15:0] rand_amp();
        case ($urandom_range(0, 5))
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            2:       return 16'($urandom_range(0, 255) - 128);
            default: return 16'($urandom());
        endcase
    endfunction

    function automatic logic [15:0] rand_coef();
        case ($urandom_range(0, 7))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return 16'd16384;
            3:       return -16'sd16384;
            4:       return 16'd0;
            default: return 16'($urandom());
        endcase
    endfunction

    // Sends one whole vector of 2^n amplitudes under the current settings.
    task automatic send_vector(input int nq);
        int size;
        size = 1 << nq;
        for (int i = 0; i < size; i++)
            send_amp(rand_amp(), rand_amp());
    endtask

    initial
    begin
        int pick;
        int nq;
        sb = new();
        burst_left = 0;
        sent_items = 0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_QUBIT_COUNT;
        cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.in_re = '0;
        in_ch.in_im = '0;
        in_ch.out_re = '0;
        in_ch.out_im = '0;
        in_ch.out_index = '0;
        in_ch.out_last = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Two qubits with the reset Hadamard gate and full-scale inputs.
        write_cfg(REG_QUBIT_COUNT, 16'd2);
        send_amp(16'sh7FFF, 16'sh8000);
        send_amp(16'sh8000, 16'sh7FFF);
        send_amp(16'sh7FFF, 16'sh7FFF);
        send_amp(16'sh8000, 16'sh8000);
        drain();

        // Most negative coefficients everywhere: the sums saturate both ways.
        write_cfg(REG_QUBIT_COUNT, 16'd1);
        write_cfg(REG_GATE_A, 16'h8000);
        write_cfg(REG_GATE_B, 16'h8000);
        write_cfg(REG_GATE_C, 16'h8000);
        write_cfg(REG_GATE_D, 16'h8000);
        send_amp(16'sh8000, 16'sh7FFF);
        send_amp(16'sh8000, 16'sh0001);
        drain();

        // A qubit count of zero behaves as one; largest positive A, B and C coefficients.
        write_cfg(REG_QUBIT_COUNT, 16'd0);
        write_cfg(REG_GATE_A, 16'h7FFF);
        write_cfg(REG_GATE_B, 16'h7FFF);
        write_cfg(REG_GATE_C, 16'h7FFF);
        write_cfg(REG_GATE_D, 16'h0001);
        send_amp(16'sh7FFF, -16'sd1);
        send_amp(16'sh0001, 16'sh0000);
        drain();

        // Writes to unused register indexes must leave every setting alone.
        write_cfg(3'd5, 16'hFFFF);
        write_cfg(3'd6, 16'h1234);
        write_cfg(3'd7, 16'h0007);

        // Qubit count lowered in the middle of a load: the next item stores
        // and completes a vector of the smaller size at once.
        write_cfg(REG_QUBIT_COUNT, 16'd3);
        send_amp(16'sd100, -16'sd100);
        send_amp(16'sd8192, 16'sd4096);
        send_amp(-16'sd8192, 16'sd1);
        drain();
        write_cfg(REG_QUBIT_COUNT, 16'd1);
        send_amp(16'sd5, -16'sd5);
        drain();

        // Random vectors. Small qubit counts dominate; a few vectors use the
        // largest size, including a count above the maximum.
        while (sent_items < 116)
        begin
            pick = $urandom_range(0, 11);
            if (pick <= 6)
                nq = $urandom_range(1, 3);
            else if (pick == 7)
                nq = 0;
            else if (pick == 8)
                nq = 4;
            else if (pick == 9)
                nq = 6;
            else if (pick == 10)
                nq = 7;
            else
                nq = 2;
            write_cfg(REG_QUBIT_COUNT, nq[15:0]);
            case ($urandom_range(0, 3))
                0:
                begin
                    write_cfg(REG_GATE_A, 16'd11585);
                    write_cfg(REG_GATE_B, 16'd11585);
                    write_cfg(REG_GATE_C, 16'd11585);
                    write_cfg(REG_GATE_D, -16'sd11585);
                end
                1:
                    ;
                default:
                begin
                    write_cfg(REG_GATE_A, rand_coef());
                    write_cfg(REG_GATE_B, rand_coef());
                    write_cfg(REG_GATE_C, rand_coef());
                    write_cfg(REG_GATE_D, rand_coef());
                end
            endcase
            if (nq == 0)
                nq = 1;
            else if (nq > MaxQubits)
                nq = MaxQubits;
            // Past the early 64-item vectors only small sizes keep the run short.
            if (nq == MaxQubits && sent_items > 50)
            begin
                write_cfg(REG_QUBIT_COUNT, 16'd2);
                nq = 2;
            end
            send_vector(nq);
            drain();
        end

        drain();
        repeat (50) @(posedge clk);
        if (sb.errors == 0 && sb.amp_queue.size() == 0)
            $display("** butterfly_gate_transform_unit: PASSED **");
        else
            $display("** butterfly_gate_transform_unit: FAILED **");
        $finish;
    end

    // Safety net against a hung handshake.
    initial
    begin
        #3ms;
        $display("** butterfly_gate_transform_unit: FAILED **");
        $finish;
    end

endmodule
